// ----- rtl/core/wsq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared types, widths and helpers for the wall segment quad expander.
// Used by the square root unit, the divider and the top level.
package wsq_pkg;

	// Square root: 63-bit radicand, 32-bit root.
	localparam int SQ_IN_W = 63;
	localparam int ROOT_W  = 32;

	// Divider: 63-bit numerator, 34-bit divisor, 31-bit quotient.
	localparam int NUM_W = 63;
	localparam int D_W   = 34;
	localparam int Q_W   = 31;

	// Number of offset magnitudes formed per segment.
	localparam int LANES = 4;

	// Segment data carried alongside the square root.
	typedef struct packed {
		logic [9:0]         sid;
		logic [9:0]         eid;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] ex;
		logic signed [31:0] ey;
		logic [30:0]        sw;
		logic [30:0]        ew;
		logic [31:0]        ax;
		logic [31:0]        ay;
		logic               negx;
		logic               negy;
		logic               degen;
	} seg_t;

	// Segment data carried alongside the divider.
	typedef struct packed {
		logic [9:0]         sid;
		logic [9:0]         eid;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] ex;
		logic signed [31:0] ey;
		logic               negx;
		logic               negy;
		logic               degen;
	} pos_t;

	// Clamp a 34-bit signed sum to the signed 32-bit range.
	function automatic logic [31:0] sat32(input logic signed [33:0] v);
		logic [31:0] r;
		if (v > 34'sh0_7FFF_FFFF) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -34'sh0_8000_0000) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/wsq_sqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Pipelined integer square root, one root bit per register stage.
// Depends on wsq_pkg for widths.
module wsq_sqrt #(
	parameter int SIDE_W = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [wsq_pkg::SQ_IN_W-1:0]  radicand,
	input  logic [SIDE_W-1:0]            side_in,
	output logic                         out_valid,
	output logic [wsq_pkg::ROOT_W-1:0]   root,
	output logic [SIDE_W-1:0]            side_out
);
	import wsq_pkg::*;

	localparam int NS    = ROOT_W;
	localparam int RAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 3;

	logic              v_r    [1:NS];
	logic [RAD_W-1:0]  rad_r  [1:NS];
	logic [REM_W-1:0]  rem_r  [1:NS];
	logic [ROOT_W-1:0] root_r [1:NS];
	logic [SIDE_W-1:0] side_r [1:NS];

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic              v_i;
		logic [RAD_W-1:0]  rad_i;
		logic [REM_W-1:0]  rem_i;
		logic [ROOT_W-1:0] root_i;
		logic [SIDE_W-1:0] side_i;
		logic [REM_W-1:0]  rem_sh;
		logic [REM_W-1:0]  trial;
		logic              ge;

		if (g == 0) begin : g_first
			assign v_i    = in_valid;
			assign rad_i  = {1'b0, radicand};
			assign rem_i  = '0;
			assign root_i = '0;
			assign side_i = side_in;
		end else begin : g_next
			assign v_i    = v_r[g];
			assign rad_i  = rad_r[g];
			assign rem_i  = rem_r[g];
			assign root_i = root_r[g];
			assign side_i = side_r[g];
		end

		// Bring down the next bit pair and try the next root bit.
		assign rem_sh = {rem_i[REM_W-3:0], rad_i[RAD_W-1 -: 2]};
		assign trial  = {1'b0, root_i, 2'b01};
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_r[g+1] <= 1'b0;
			end else if (en) begin
				v_r[g+1] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_r[g+1]  <= ge ? (rem_sh - trial) : rem_sh;
				root_r[g+1] <= {root_i[ROOT_W-2:0], ge};
				rad_r[g+1]  <= {rad_i[RAD_W-3:0], 2'b00};
				side_r[g+1] <= side_i;
			end
		end
	end

	assign out_valid = v_r[NS];
	assign root      = root_r[NS];
	assign side_out  = side_r[NS];

endmodule
`default_nettype wire

// ----- rtl/core/wsq_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider, several numerators over one shared divisor,
// one quotient bit per register stage. Depends on wsq_pkg for widths.
module wsq_div #(
	parameter int SIDE_W = 1
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         en,
	input  logic                                         in_valid,
	input  logic [wsq_pkg::LANES-1:0][wsq_pkg::NUM_W-1:0] num,
	input  logic [wsq_pkg::D_W-1:0]                      den,
	input  logic [SIDE_W-1:0]                            side_in,
	output logic                                         out_valid,
	output logic [wsq_pkg::LANES-1:0][wsq_pkg::Q_W-1:0]   quo,
	output logic [SIDE_W-1:0]                            side_out
);
	import wsq_pkg::*;

	localparam int NS = Q_W;

	logic                           v_r    [1:NS];
	logic [D_W-1:0]                 d_r    [1:NS];
	logic [LANES-1:0][D_W-1:0]      rem_r  [1:NS];
	logic [LANES-1:0][Q_W-1:0]      lo_r   [1:NS];
	logic [LANES-1:0][Q_W-1:0]      q_r    [1:NS];
	logic [SIDE_W-1:0]              side_r [1:NS];

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic                      v_i;
		logic [D_W-1:0]            d_i;
		logic [LANES-1:0][D_W-1:0] rem_i;
		logic [LANES-1:0][Q_W-1:0] lo_i;
		logic [LANES-1:0][Q_W-1:0] q_i;
		logic [SIDE_W-1:0]         side_i;
		logic [LANES-1:0][D_W-1:0] rem_n;
		logic [LANES-1:0][Q_W-1:0] q_n;

		if (g == 0) begin : g_first
			assign v_i    = in_valid;
			assign d_i    = den;
			assign q_i    = '0;
			assign side_i = side_in;
			for (genvar l = 0; l < LANES; l++) begin : g_lane
				assign rem_i[l] = {{(D_W-(NUM_W-Q_W)){1'b0}}, num[l][NUM_W-1:Q_W]};
				assign lo_i[l]  = num[l][Q_W-1:0];
			end
		end else begin : g_next
			assign v_i    = v_r[g];
			assign d_i    = d_r[g];
			assign rem_i  = rem_r[g];
			assign lo_i   = lo_r[g];
			assign q_i    = q_r[g];
			assign side_i = side_r[g];
		end

		// One trial subtraction per lane.
		always_comb begin
			logic [D_W-1:0] sh;
			for (int l = 0; l < LANES; l++) begin
				sh = {rem_i[l][D_W-2:0], lo_i[l][Q_W-1]};
				if (sh >= d_i) begin
					rem_n[l] = sh - d_i;
					q_n[l]   = {q_i[l][Q_W-2:0], 1'b1};
				end else begin
					rem_n[l] = sh;
					q_n[l]   = {q_i[l][Q_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_r[g+1] <= 1'b0;
			end else if (en) begin
				v_r[g+1] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d_r[g+1]    <= d_i;
				rem_r[g+1]  <= rem_n;
				q_r[g+1]    <= q_n;
				side_r[g+1] <= side_i;
				for (int l = 0; l < LANES; l++) begin
					lo_r[g+1][l] <= {lo_i[l][Q_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = v_r[NS];
	assign quo       = q_r[NS];
	assign side_out  = side_r[NS];

endmodule
`default_nettype wire

// ----- rtl/core/wall_segment_quad_expander.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Wall segment quad expander.
// Each beat on the slave stream is one wall segment: node ids, end positions
// and wall widths. For each segment the master stream carries four corner
// beats in the order start-left, end-left, end-right, start-right; tlast
// marks the fourth and tuser carries the zero-length flag.
// From an accepted segment to its first corner the data passes four
// stages for the differences, magnitudes and squares, 32 stages of the
// square root (one root bit each), two stages for the width products and
// then the rounding term and divisor, 31 stages of the divider (one
// quotient bit each) and the corner output register.
// The pipeline takes a segment in every cycle it moves; the master stream
// sends one corner per cycle while m_tready is high, four per segment.
// When the receiver stalls, the pipeline freezes as soon as a finished
// segment waits for the corner register; nothing is dropped or repeated.
// Reset clears all valid bits and the corner counter; no clearing pass.
// Depends on wsq_pkg, wsq_sqrt and wsq_div.
module wall_segment_quad_expander #(
	parameter int MAX_NODES = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// start_id, end_id, start_x, start_y, end_x, end_y, start_width, end_width
	input  logic [215:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// point_index, point_x, point_y
	output logic [79:0]  m_tdata,
	// degenerate
	output logic [0:0]   m_tuser,
	output logic         m_tlast
);
	import wsq_pkg::*;

	logic adv;

	// Input field unpacking.
	logic [9:0]         in_sid, in_eid;
	logic signed [31:0] in_sx, in_sy, in_ex, in_ey;
	logic [30:0]        in_sw, in_ew;

	assign in_sid = s_tdata[9:0];
	assign in_eid = s_tdata[19:10];
	assign in_sx  = s_tdata[51:20];
	assign in_sy  = s_tdata[83:52];
	assign in_ex  = s_tdata[115:84];
	assign in_ey  = s_tdata[147:116];
	assign in_sw  = s_tdata[178:148];
	assign in_ew  = s_tdata[209:179];

	// Node id reduction, upper steps.
	logic [9:0] sid_m1, eid_m1;
	always_comb begin
		sid_m1 = in_sid;
		eid_m1 = in_eid;
		for (int k = 9; k >= 5; k--) begin
			if ((MAX_NODES << k) < 1024) begin
				if (32'(sid_m1) >= (MAX_NODES << k)) sid_m1 = sid_m1 - 10'(MAX_NODES << k);
				if (32'(eid_m1) >= (MAX_NODES << k)) eid_m1 = eid_m1 - 10'(MAX_NODES << k);
			end
		end
	end

	// Stage 1: register the beat and form the differences.
	logic               v_s1;
	logic [9:0]         sid_s1, eid_s1;
	logic signed [31:0] sx_s1, sy_s1, ex_s1, ey_s1;
	logic [30:0]        sw_s1, ew_s1;
	logic signed [32:0] dx_s1, dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sid_s1 <= sid_m1;
			eid_s1 <= eid_m1;
			sx_s1  <= in_sx;
			sy_s1  <= in_sy;
			ex_s1  <= in_ex;
			ey_s1  <= in_ey;
			sw_s1  <= in_sw;
			ew_s1  <= in_ew;
			dx_s1  <= {in_ex[31], in_ex} - {in_sx[31], in_sx};
			dy_s1  <= {in_ey[31], in_ey} - {in_sy[31], in_sy};
		end
	end

	// Stage 2: magnitudes, range halving, rest of the id reduction.
	logic [32:0] ax_f, ay_f;
	logic        big;
	logic [9:0]  sid_m2, eid_m2;

	assign ax_f = dx_s1[32] ? 33'(-dx_s1) : 33'(dx_s1);
	assign ay_f = dy_s1[32] ? 33'(-dy_s1) : 33'(dy_s1);
	assign big  = ax_f[32] | ax_f[31] | ay_f[32] | ay_f[31];

	always_comb begin
		sid_m2 = sid_s1;
		eid_m2 = eid_s1;
		for (int k = 4; k >= 0; k--) begin
			if ((MAX_NODES << k) < 1024) begin
				if (32'(sid_m2) >= (MAX_NODES << k)) sid_m2 = sid_m2 - 10'(MAX_NODES << k);
				if (32'(eid_m2) >= (MAX_NODES << k)) eid_m2 = eid_m2 - 10'(MAX_NODES << k);
			end
		end
	end

	logic v_s2;
	seg_t seg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seg_s2.sid   <= sid_m2;
			seg_s2.eid   <= eid_m2;
			seg_s2.sx    <= sx_s1;
			seg_s2.sy    <= sy_s1;
			seg_s2.ex    <= ex_s1;
			seg_s2.ey    <= ey_s1;
			seg_s2.sw    <= sw_s1;
			seg_s2.ew    <= ew_s1;
			seg_s2.ax    <= big ? ax_f[32:1] : ax_f[31:0];
			seg_s2.ay    <= big ? ay_f[32:1] : ay_f[31:0];
			seg_s2.negx  <= dx_s1[32];
			seg_s2.negy  <= dy_s1[32];
			seg_s2.degen <= (dx_s1 == 33'sd0) && (dy_s1 == 33'sd0);
		end
	end

	// Stage 3: squares.
	logic        v_s3;
	seg_t        seg_s3;
	logic [63:0] sqx_s3, sqy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seg_s3 <= seg_s2;
			sqx_s3 <= seg_s2.ax * seg_s2.ax;
			sqy_s3 <= seg_s2.ay * seg_s2.ay;
		end
	end

	// Stage 4: sum of squares.
	logic                v_s4;
	seg_t                seg_s4;
	logic [SQ_IN_W-1:0]  rad_s4;
	logic [63:0]         sq_sum;

	assign sq_sum = sqx_s3 + sqy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seg_s4 <= seg_s3;
			rad_s4 <= sq_sum[SQ_IN_W-1:0];
		end
	end

	// Segment length.
	logic              v_sq;
	logic [ROOT_W-1:0] len_sq;
	seg_t              seg_sq;

	wsq_sqrt #(
		.SIDE_W($bits(seg_t))
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s4),
		.radicand (rad_s4),
		.side_in  (seg_s4),
		.out_valid(v_sq),
		.root     (len_sq),
		.side_out (seg_sq)
	);

	// Stage 5: width products. A zero length only comes with zero
	// magnitudes, so a length of one there still gives zero offsets.
	logic                        v_s5;
	pos_t                        pos_s5;
	logic [ROOT_W-1:0]           lp_s5;
	logic [LANES-1:0][NUM_W-1:0] pr_s5;
	pos_t                        pos_sq;

	assign pos_sq.sid   = seg_sq.sid;
	assign pos_sq.eid   = seg_sq.eid;
	assign pos_sq.sx    = seg_sq.sx;
	assign pos_sq.sy    = seg_sq.sy;
	assign pos_sq.ex    = seg_sq.ex;
	assign pos_sq.ey    = seg_sq.ey;
	assign pos_sq.negx  = seg_sq.negx;
	assign pos_sq.negy  = seg_sq.negy;
	assign pos_sq.degen = seg_sq.degen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_sq;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s5   <= pos_sq;
			lp_s5    <= (len_sq == '0) ? ROOT_W'(1) : len_sq;
			pr_s5[0] <= seg_sq.sw * seg_sq.ay;
			pr_s5[1] <= seg_sq.sw * seg_sq.ax;
			pr_s5[2] <= seg_sq.ew * seg_sq.ay;
			pr_s5[3] <= seg_sq.ew * seg_sq.ax;
		end
	end

	// Stage 6: rounding term and divisor.
	logic                        v_s6;
	pos_t                        pos_s6;
	logic [LANES-1:0][NUM_W-1:0] num_s6;
	logic [D_W-1:0]              den_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s6 <= pos_s5;
			den_s6 <= {1'b0, lp_s5, 1'b0};
			for (int l = 0; l < LANES; l++) begin
				num_s6[l] <= pr_s5[l] + {{(NUM_W-ROOT_W){1'b0}}, lp_s5};
			end
		end
	end

	// Offset magnitudes.
	logic                      v_dv;
	logic [LANES-1:0][Q_W-1:0] quo_dv;
	pos_t                      pos_dv;

	wsq_div #(
		.SIDE_W($bits(pos_t))
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s6),
		.num      (num_s6),
		.den      (den_s6),
		.side_in  (pos_s6),
		.out_valid(v_dv),
		.quo      (quo_dv),
		.side_out (pos_dv)
	);

	// Signed left-hand offsets and saturated corners.
	logic signed [32:0] mx1, my1, mx2, my2;
	logic signed [32:0] u1x, u1y, u2x, u2y;
	logic signed [33:0] sx_e, sy_e, ex_e, ey_e;
	logic [31:0]        cx [4];
	logic [31:0]        cy [4];

	assign mx1 = {2'b00, quo_dv[0]};
	assign my1 = {2'b00, quo_dv[1]};
	assign mx2 = {2'b00, quo_dv[2]};
	assign my2 = {2'b00, quo_dv[3]};
	assign u1x = pos_dv.negy ? mx1 : -mx1;
	assign u1y = pos_dv.negx ? -my1 : my1;
	assign u2x = pos_dv.negy ? mx2 : -mx2;
	assign u2y = pos_dv.negx ? -my2 : my2;
	assign sx_e = {{2{pos_dv.sx[31]}}, pos_dv.sx};
	assign sy_e = {{2{pos_dv.sy[31]}}, pos_dv.sy};
	assign ex_e = {{2{pos_dv.ex[31]}}, pos_dv.ex};
	assign ey_e = {{2{pos_dv.ey[31]}}, pos_dv.ey};

	assign cx[0] = sat32(sx_e + {u1x[32], u1x});
	assign cy[0] = sat32(sy_e + {u1y[32], u1y});
	assign cx[1] = sat32(ex_e + {u2x[32], u2x});
	assign cy[1] = sat32(ey_e + {u2y[32], u2y});
	assign cx[2] = sat32(ex_e - {u2x[32], u2x});
	assign cy[2] = sat32(ey_e - {u2y[32], u2y});
	assign cx[3] = sat32(sx_e - {u1x[32], u1x});
	assign cy[3] = sat32(sy_e - {u1y[32], u1y});

	// Corner output register: holds one segment and sends its four beats.
	logic        out_v_q;
	logic [1:0]  cnt_q;
	logic        degen_q;
	logic [31:0] px_q [4];
	logic [31:0] py_q [4];
	logic [10:0] pidx_q [4];
	logic        load;
	logic        beat;

	assign beat = out_v_q && m_tready;
	assign load = v_dv && (!out_v_q || (beat && (cnt_q == 2'd3)));
	assign adv  = !v_dv || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			cnt_q   <= 2'd0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
				cnt_q   <= 2'd0;
			end else if (beat) begin
				out_v_q <= (cnt_q != 2'd3);
				cnt_q   <= cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			degen_q   <= pos_dv.degen;
			px_q      <= cx;
			py_q      <= cy;
			pidx_q[0] <= {pos_dv.sid, 1'b0};
			pidx_q[1] <= {pos_dv.eid, 1'b0};
			pidx_q[2] <= {pos_dv.eid, 1'b1};
			pidx_q[3] <= {pos_dv.sid, 1'b1};
		end
	end

	assign s_tready = adv;
	assign m_tvalid = out_v_q;
	assign m_tdata  = {5'b0, py_q[cnt_q], px_q[cnt_q], pidx_q[cnt_q]};
	assign m_tuser  = degen_q;
	assign m_tlast  = (cnt_q == 2'd3);

	// Checks on the corner register and the pipeline stall.
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_v_q |-> (cnt_q == 2'd0))
		else $error("corner counter moved without a held segment");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready && v_dv) |-> !s_tready)
		else $error("pipeline advanced while a finished segment was blocked");

	a_quad_continue: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
		else $error("segment corners broken off before the fourth beat");

endmodule
`default_nettype wire

// ----- tb/sv/wall_segment_quad_expander_tb.sv -----
`timescale 1ns / 1ps
// Testbench for the wall segment quad expander: drives wall segments on the
// slave stream and checks every corner beat against a built-in predictor.
// Depends on the wall_segment_quad_expander top level and its package.
module wall_segment_quad_expander_tb;

	localparam int MAX_NODES  = 1024;
	localparam bit SIDE_LEFT  = 1'b0;
	localparam bit SIDE_RIGHT = 1'b1;
	localparam int DRAIN_WAIT = 100;

	typedef struct {
		bit [9:0]  sid;
		bit [9:0]  eid;
		bit [31:0] sx;
		bit [31:0] sy;
		bit [31:0] ex;
		bit [31:0] ey;
		bit [30:0] sw;
		bit [30:0] ew;
	} segment_t;

	typedef struct {
		bit [10:0] idx;
		bit [31:0] x;
		bit [31:0] y;
		bit        degen;
		bit        last;
	} corner_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [215:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [79:0]  m_tdata;
	logic [0:0]   m_tuser;
	logic         m_tlast;

	corner_t pending_corners[$];
	int      mismatch_count;
	int      tx_idle_pct;
	int      rx_idle_pct;
	int      hold_request;

	wall_segment_quad_expander #(.MAX_NODES(MAX_NODES)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// Clock with an 8 ns period.
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Integer square root, rounded down.
	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n = n - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// Clamp an exact sum to the signed 32-bit range.
	function automatic bit [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic bit [10:0] point_slot(bit [9:0] id, bit side);
		int n;
		n = int'(id) % MAX_NODES;
		return 11'(2 * n + int'(side));
	endfunction

	// Works out the four corners of one segment and queues them.
	task automatic push_corners(segment_t s);
		longint          sx, sy, ex, ey, dx, dy;
		longint          u1x, u1y, u2x, u2y;
		longint unsigned ax, ay, len, mx, my;
		bit              negx, negy, degen;
		corner_t         c[4];
		sx = longint'($signed(s.sx));
		sy = longint'($signed(s.sy));
		ex = longint'($signed(s.ex));
		ey = longint'($signed(s.ey));
		dx = ex - sx;
		dy = ey - sy;
		negx = dx < 0;
		negy = dy < 0;
		ax = negx ? -dx : dx;
		ay = negy ? -dy : dy;
		// Halve both magnitudes when either is too wide to square safely.
		if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) begin
			ax = ax >> 1;
			ay = ay >> 1;
		end
		len = int_sqrt(ax * ax + ay * ay);
		degen = (dx == 0 && dy == 0);
		u1x = 0; u1y = 0; u2x = 0; u2y = 0;
		if (!degen && len != 0) begin
			mx = (64'(s.sw) * ay + len) / (2 * len);
			my = (64'(s.sw) * ax + len) / (2 * len);
			u1x = negy ? longint'(mx) : -longint'(mx);
			u1y = negx ? -longint'(my) : longint'(my);
			mx = (64'(s.ew) * ay + len) / (2 * len);
			my = (64'(s.ew) * ax + len) / (2 * len);
			u2x = negy ? longint'(mx) : -longint'(mx);
			u2y = negx ? -longint'(my) : longint'(my);
		end
		c[0] = '{point_slot(s.sid, SIDE_LEFT), clamp32(sx + u1x), clamp32(sy + u1y), degen, 1'b0};
		c[1] = '{point_slot(s.eid, SIDE_LEFT), clamp32(ex + u2x), clamp32(ey + u2y), degen, 1'b0};
		c[2] = '{point_slot(s.eid, SIDE_RIGHT), clamp32(ex - u2x), clamp32(ey - u2y), degen, 1'b0};
		c[3] = '{point_slot(s.sid, SIDE_RIGHT), clamp32(sx - u1x), clamp32(sy - u1y), degen, 1'b1};
		for (int k = 0; k < 4; k++) pending_corners.insert(pending_corners.size(), c[k]);
	endtask

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// Sends one segment beat, with a random gap first, and records its corners.
	task automatic send_segment(segment_t s);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct && gap < 20) gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, s.ew, s.sw, s.ey, s.ex, s.sy, s.sx, s.eid, s.sid};
		do @(posedge clk); while (!s_tready);
		push_corners(s);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_corners.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic bit [31:0] random_coord();
		case ($urandom_range(3))
			0: return $urandom();
			1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
			2: return $urandom_range(1) ? 32'h7FFF_0000 + $urandom_range(65535)
				: 32'h8000_0000 + $urandom_range(65535);
			default: return 32'($signed($urandom_range(200000)) - 100000);
		endcase
	endfunction

	function automatic bit [30:0] random_width();
		case ($urandom_range(3))
			0: return 31'($urandom());
			1: return 31'($urandom_range(64) << 16);
			2: return 31'($urandom_range(255));
			default: return 31'(32'h7FFF_FFFF - $urandom_range(65535));
		endcase
	endfunction

	function automatic segment_t random_segment();
		segment_t s;
		s.sid = 10'($urandom());
		s.eid = 10'($urandom());
		s.sx  = random_coord();
		s.sy  = random_coord();
		s.ex  = random_coord();
		s.ey  = random_coord();
		s.sw  = random_width();
		s.ew  = random_width();
		// A few zero-length segments.
		if ($urandom_range(15) == 0) begin
			s.ex = s.sx;
			s.ey = s.sy;
		end
		return s;
	endfunction

	// Receiver: random stalls, plus a long hold-off when a test asks for one.
	initial begin
		int stall_left;
		int hold_taken;
		stall_left = 0;
		hold_taken = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != hold_taken) begin
				hold_taken = hold_request;
				stall_left = 400;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Compare each corner beat with the oldest expected corner.
	always @(posedge clk) begin
		corner_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_corners.size() == 0) begin
				report_mismatch("unexpected corner", m_tdata, 0);
			end else begin
				want = pending_corners.pop_front();
				if (m_tdata[10:0] != want.idx) report_mismatch("point_index", m_tdata[10:0], want.idx);
				if (m_tdata[42:11] != want.x) report_mismatch("point_x", m_tdata[42:11], want.x);
				if (m_tdata[74:43] != want.y) report_mismatch("point_y", m_tdata[74:43], want.y);
				if (m_tdata[79:75] != 5'd0) report_mismatch("tdata pad", m_tdata[79:75], 0);
				if (m_tuser[0] != want.degen) report_mismatch("degenerate", m_tuser[0], want.degen);
				if (m_tlast != want.last) report_mismatch("last_corner", m_tlast, want.last);
			end
		end
	end

	// Extremes, zero length, axis-aligned and saturating segments.
	task automatic test_directed();
		segment_t s;
		tx_idle_pct = 10;
		rx_idle_pct = 10;
		s = '{10'd0, 10'd1023, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 31'h0002_0000, 31'h0004_0000};
		send_segment(s);
		s = '{10'd1023, 10'd0, 32'h0, 32'h0, 32'h0, 32'hFFFF_0000, 31'h7FFF_FFFF, 31'h0};
		send_segment(s);
		s = '{10'd5, 10'd5, 32'h1234_5678, 32'h8765_4321, 32'h1234_5678, 32'h8765_4321,
			31'h7FFF_FFFF, 31'h7FFF_FFFF};
		send_segment(s);
		s = '{10'd3, 10'd4, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			31'h7FFF_FFFF, 31'h7FFF_FFFF};
		send_segment(s);
		s = '{10'd7, 10'd8, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0, 31'h7FFF_FFFF, 31'h1};
		send_segment(s);
		s = '{10'd9, 10'd10, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 31'h1, 31'h7FFF_FFFF};
		send_segment(s);
		s = '{10'd11, 10'd12, 32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_0001, 32'h7FFF_0000,
			31'h7FFF_FFFF, 31'h7FFF_FFFF};
		send_segment(s);
		s = '{10'd13, 10'd14, 32'h0, 32'h0, 32'h1, 32'h1, 31'h0001_0000, 31'h0001_0000};
		send_segment(s);
		s = '{10'd15, 10'd16, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			31'h0, 31'h0};
		send_segment(s);
		s = '{10'd17, 10'd18, 32'hFFFF_0000, 32'h0003_0000, 32'h0002_0000, 32'hFFFF_0000,
			31'h0003_0000, 31'h0001_8000};
		send_segment(s);
		s = '{10'd1022, 10'd1021, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h0};
		send_segment(s);
		wait_drained();
	endtask

	task automatic test_random(int count, int tx_pct, int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		repeat (count) send_segment(random_segment());
		wait_drained();
	endtask

	// Long receiver hold-off while segments keep coming, so the input stalls.
	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_request++;
		repeat (120) send_segment(random_segment());
		wait_drained();
	endtask

	// Limit on the whole run.
	initial begin
		#3_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		mismatch_count = 0;
		hold_request   = 0;
		tx_idle_pct    = 0;
		rx_idle_pct    = 0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(110, 32, 78);
		test_random(110, 78, 32);
		test_random(110, 0, 0);
		test_backpressure();
		if (pending_corners.size() != 0)
			report_mismatch("corners never produced", pending_corners.size(), 0);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ----- wall_segment_quad_expander.f -----
rtl/core/wsq_pkg.sv
rtl/core/wsq_sqrt.sv
rtl/core/wsq_div.sv
rtl/core/wall_segment_quad_expander.sv
tb/sv/wall_segment_quad_expander_tb.sv
